// ===== sv/mexp_pkg.sv =====
// shared types and constants for the modular exponentiation block
package mexp_pkg;

    // datapath commands from the controller
    typedef struct packed {
        logic load;     // capture operands, start base reduction
        logic square;   // start acc = acc * acc mod m
        logic mult;     // start acc = acc * b mod m
    } mexp_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic busy;     // a reduction is in progress
    } mexp_sts_t;

    localparam logic [30:0] MODULUS_RESET = 31'd1000000007;
    localparam logic        OP_POWER      = 1'b0;
    localparam logic        OP_INVERSE    = 1'b1;

endpackage

// ===== sv/mexp_datapath.sv =====
// modular multiply datapath: one product, then bit-serial reduction
module mexp_datapath import mexp_pkg::*; #(
    parameter int MOD_BITS = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mexp_cmd_t             cmd,
    output mexp_sts_t             sts,
    input  logic [MOD_BITS-1:0]   modulus,
    input  logic [30:0]           base,
    output logic [MOD_BITS-1:0]   acc
);
    // product width also holds a full 31-bit base for the first reduction
    localparam int PW = (2 * MOD_BITS > 31) ? 2 * MOD_BITS : 31;
    localparam int CW = $clog2(PW + 1);

    logic [MOD_BITS-1:0] b_reg, b_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [MOD_BITS:0]   rem_reg, rem_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                tob_reg, tob_next;
    logic [MOD_BITS:0]   sh;
    logic [MOD_BITS:0]   diff;

    assign sts.busy = busy_reg;
    assign acc      = acc_reg;

    // one remainder bit per cycle, msb first
    always_comb begin
        sh   = {rem_reg[MOD_BITS-1:0], prod_reg[PW-1]};
        diff = sh - {1'b0, modulus};
    end

    always_comb begin
        b_next    = b_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        tob_next  = tob_reg;
        if (cmd.load) begin
            // reduce base: product = base * 1, result goes to b
            prod_next = PW'(base);
            rem_next  = '0;
            cnt_next  = CW'(PW);
            busy_next = 1'b1;
            tob_next  = 1'b1;
            acc_next  = MOD_BITS'(1);
        end else if (cmd.square || cmd.mult) begin
            prod_next = PW'(acc_reg) * PW'(cmd.square ? acc_reg : b_reg);
            rem_next  = '0;
            cnt_next  = CW'(PW);
            busy_next = 1'b1;
            tob_next  = 1'b0;
        end else if (busy_reg) begin
            prod_next = {prod_reg[PW-2:0], 1'b0};
            rem_next  = diff[MOD_BITS] ? sh : diff;
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                if (tob_reg) b_next = MOD_BITS'(diff[MOD_BITS] ? sh : diff);
                else acc_next = MOD_BITS'(diff[MOD_BITS] ? sh : diff);
            end
        end
    end

    // control clears on reset, payload does not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        tob_reg  <= tob_next;
    end
endmodule

// ===== sv/mexp_ctrl.sv =====
// controller: handshakes and the exponent bit scan
module mexp_ctrl import mexp_pkg::*; #(
    parameter int EXP_BITS = 64,
    parameter int MOD_BITS = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [62:0]         s_exponent,
    input  logic [MOD_BITS-1:0] modulus,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                force_one,
    output logic                force_zero,
    output mexp_cmd_t           cmd,
    input  mexp_sts_t           sts
);
    localparam int        IW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_BASE = 3'd1, ST_SQ = 3'd2,
                           ST_MUL = 3'd3, ST_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [EXP_BITS-1:0] e_reg, e_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                one_reg, one_next, zero_reg, zero_next;
    logic [63:0]         e_in;
    logic [EXP_BITS-1:0] e_sel;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_DONE);
    assign force_one  = one_reg;
    assign force_zero = zero_reg;

    // effective exponent for either operation
    always_comb begin
        if (s_opcode == OP_INVERSE) e_in = 64'(modulus) - 64'd2;
        else                        e_in = {1'b0, s_exponent};
        e_sel = e_in[EXP_BITS-1:0];
    end

    always_comb begin
        state_next = state_reg;
        e_next     = e_reg;
        idx_next   = idx_reg;
        one_next   = one_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    e_next   = e_sel;
                    idx_next = IW'(EXP_BITS - 1);
                    if (s_opcode == OP_INVERSE && modulus < MOD_BITS'(2)) begin
                        one_next = 1'b0; zero_next = 1'b1; state_next = ST_DONE;
                    end else if (e_sel == '0) begin
                        one_next = 1'b1; zero_next = 1'b0; state_next = ST_DONE;
                    end else if (modulus < MOD_BITS'(2)) begin
                        one_next = 1'b0; zero_next = 1'b1; state_next = ST_DONE;
                    end else begin
                        one_next = 1'b0; zero_next = 1'b0;
                        cmd.load = 1'b1; state_next = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                if (!sts.busy) begin
                    cmd.square = 1'b1; state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (!sts.busy) begin
                    if (e_reg[idx_reg]) begin
                        cmd.mult = 1'b1; state_next = ST_MUL;
                    end else if (idx_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg - IW'(1);
                        cmd.square = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                if (!sts.busy) begin
                    if (idx_reg == '0) state_next = ST_DONE;
                    else begin
                        idx_next = idx_reg - IW'(1);
                        cmd.square = 1'b1; state_next = ST_SQ;
                    end
                end
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        e_reg    <= e_next;
        idx_reg  <= idx_next;
        one_reg  <= one_next;
        zero_reg <= zero_next;
    end
endmodule

// ===== sv/modular_exponentiation.sv =====
// top level of the modular exponentiation block
//   channel | ports                               | direction
//   input   | s_valid s_ready s_opcode s_base ... | in
//   result  | m_valid m_ready m_value             | out
//   config  | cfg_we cfg_data                     | in
// one item at a time; the item starts a base reduction, then one squaring per
// exponent bit and one multiply per set bit, each a product and a bit-serial
// reduction over 2*MOD_BITS product bits (31 when MOD_BITS is below 16)
// a zero exponent or a modulus below two goes straight to the result
// synchronous active-low reset; modulus resets to 1000000007
// a stalled result holds, and no new item is taken until it leaves
module modular_exponentiation import mexp_pkg::*; #(
    parameter int EXP_BITS = 64,
    parameter int MOD_BITS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [30:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [30:0] s_base,
    input  logic [62:0] s_exponent,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_value
);
    logic [MOD_BITS-1:0] mod_reg;
    logic [MOD_BITS-1:0] acc;
    logic                force_one, force_zero;
    mexp_cmd_t           cmd;
    mexp_sts_t           sts;

    // modulus register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= MODULUS_RESET[MOD_BITS-1:0];
        end else if (cfg_we) begin
            mod_reg <= cfg_data[MOD_BITS-1:0];
        end
    end

    mexp_ctrl #(.EXP_BITS(EXP_BITS), .MOD_BITS(MOD_BITS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_exponent,
        .modulus(mod_reg), .m_valid, .m_ready, .force_one, .force_zero,
        .cmd, .sts
    );

    mexp_datapath #(.MOD_BITS(MOD_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .sts, .modulus(mod_reg),
        .base(s_base), .acc
    );

    // result select
    always_comb begin
        if (force_one)       m_value = 31'd1;
        else if (force_zero) m_value = '0;
        else                 m_value = 31'(acc);
    end
endmodule
